// ===== src/pmt_pp_pkg.sv =====
// Package for the PMT section payload parser: record kinds, parse phases,
// the output record type and the output queue sizing.
// No dependencies; every other file of the block uses it.
package pmt_pp_pkg;

    // Reserved-bit masks of the PID and length fields.
    localparam logic [12:0] PID_MASK = 13'h1FFF;
    localparam logic [11:0] LEN_MASK = 12'h0FFF;

    // Output queue sizing: room for two records per word plus slack.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [2:0] {
        REC_PCR       = 3'd0,
        REC_PROG_DESC = 3'd1,
        REC_STREAM    = 3'd2,
        REC_ES_DESC   = 3'd3,
        REC_END       = 3'd4
    } rec_kind_t;

    typedef enum logic [2:0] {
        PH_PCR_HI    = 3'd0,
        PH_PCR_LO    = 3'd1,
        PH_LEN_HI    = 3'd2,
        PH_LEN_LO    = 3'd3,
        PH_PROG_DESC = 3'd4,
        PH_HEADER    = 3'd5,
        PH_ES_DESC   = 3'd6
    } phase_t;

    // Header byte positions within an elementary stream header.
    localparam logic [2:0] HDR_TYPE   = 3'd0;
    localparam logic [2:0] HDR_PID_HI = 3'd1;
    localparam logic [2:0] HDR_PID_LO = 3'd2;
    localparam logic [2:0] HDR_LEN_HI = 3'd3;
    localparam logic [2:0] HDR_LEN_LO = 3'd4;

    typedef struct packed {
        rec_kind_t   kind;
        logic [12:0] pid;
        logic [7:0]  stype;
        logic [7:0]  dbyte;
        logic        ok;
        logic        run_last;
    } rec_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
        logic                room;
    } oq_status_t;

endpackage

// ===== src/pmt_pp_parser.sv =====
// Parse state and record generation for one payload word per cycle while fire is high.
// Depends on pmt_pp_pkg for phases, record kinds and the record type.
module pmt_pp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [7:0]        byte_in,
    input  logic              last_in,
    output pmt_pp_pkg::rec_t  rec_a,
    output pmt_pp_pkg::rec_t  rec_b,
    output logic [1:0]        rec_cnt
);

    pmt_pp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]         hidx_reg, hidx_next;
    logic [11:0]        left_reg, left_next;
    logic [7:0]         high_reg, high_next;
    logic [12:0]        pid_reg, pid_next;
    logic [7:0]         type_reg, type_next;
    logic               fdone_reg, fdone_next;

    logic [15:0]        word;
    logic [11:0]        left_dec;
    logic               has_main;
    pmt_pp_pkg::rec_t   main_rec;
    pmt_pp_pkg::rec_t   end_rec;

    assign word     = {high_reg, byte_in};
    assign left_dec = left_reg - 12'd1;

    // Next state and the record caused by the current word.
    always_comb begin
        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        left_next  = left_reg;
        high_next  = high_reg;
        pid_next   = pid_reg;
        type_next  = type_reg;
        fdone_next = fdone_reg;
        has_main   = 1'b0;
        main_rec   = '0;

        case (phase_reg)
            pmt_pp_pkg::PH_PCR_LO: begin
                pid_next       = word[12:0] & pmt_pp_pkg::PID_MASK;
                has_main       = 1'b1;
                main_rec.kind  = pmt_pp_pkg::REC_PCR;
                main_rec.pid   = word[12:0] & pmt_pp_pkg::PID_MASK;
                phase_next     = pmt_pp_pkg::PH_LEN_HI;
            end
            pmt_pp_pkg::PH_LEN_HI: begin
                high_next  = byte_in;
                phase_next = pmt_pp_pkg::PH_LEN_LO;
            end
            pmt_pp_pkg::PH_LEN_LO: begin
                left_next  = word[11:0] & pmt_pp_pkg::LEN_MASK;
                fdone_next = 1'b1;
                hidx_next  = pmt_pp_pkg::HDR_TYPE;
                phase_next = ((word[11:0] & pmt_pp_pkg::LEN_MASK) != 12'd0)
                           ? pmt_pp_pkg::PH_PROG_DESC : pmt_pp_pkg::PH_HEADER;
            end
            pmt_pp_pkg::PH_PROG_DESC: begin
                has_main       = 1'b1;
                main_rec.kind  = pmt_pp_pkg::REC_PROG_DESC;
                main_rec.dbyte = byte_in;
                left_next      = left_dec;
                if (left_dec == 12'd0) begin
                    hidx_next  = pmt_pp_pkg::HDR_TYPE;
                    phase_next = pmt_pp_pkg::PH_HEADER;
                end
            end
            pmt_pp_pkg::PH_HEADER: begin
                case (hidx_reg)
                    pmt_pp_pkg::HDR_TYPE: begin
                        type_next = byte_in;
                        hidx_next = pmt_pp_pkg::HDR_PID_HI;
                    end
                    pmt_pp_pkg::HDR_PID_HI, pmt_pp_pkg::HDR_LEN_HI: begin
                        high_next = byte_in;
                        hidx_next = hidx_reg + 3'd1;
                    end
                    pmt_pp_pkg::HDR_PID_LO: begin
                        pid_next  = word[12:0] & pmt_pp_pkg::PID_MASK;
                        hidx_next = pmt_pp_pkg::HDR_LEN_HI;
                    end
                    default: begin
                        // Final header byte: the entry record goes out here.
                        left_next      = word[11:0] & pmt_pp_pkg::LEN_MASK;
                        has_main       = 1'b1;
                        main_rec.kind  = pmt_pp_pkg::REC_STREAM;
                        main_rec.pid   = pid_reg;
                        main_rec.stype = type_reg;
                        hidx_next      = pmt_pp_pkg::HDR_TYPE;
                        phase_next = ((word[11:0] & pmt_pp_pkg::LEN_MASK) != 12'd0)
                                   ? pmt_pp_pkg::PH_ES_DESC : pmt_pp_pkg::PH_HEADER;
                    end
                endcase
            end
            pmt_pp_pkg::PH_ES_DESC: begin
                has_main       = 1'b1;
                main_rec.kind  = pmt_pp_pkg::REC_ES_DESC;
                main_rec.pid   = pid_reg;
                main_rec.stype = type_reg;
                main_rec.dbyte = byte_in;
                left_next      = left_dec;
                if (left_dec == 12'd0) begin
                    hidx_next  = pmt_pp_pkg::HDR_TYPE;
                    phase_next = pmt_pp_pkg::PH_HEADER;
                end
            end
            default: begin
                high_next  = byte_in;
                phase_next = pmt_pp_pkg::PH_PCR_LO;
            end
        endcase

        // The final word of a section returns the parser to its reset state.
        if (last_in) begin
            phase_next = pmt_pp_pkg::PH_PCR_HI;
            hidx_next  = pmt_pp_pkg::HDR_TYPE;
            left_next  = 12'd0;
            high_next  = 8'd0;
            pid_next   = 13'd0;
            type_next  = 8'd0;
            fdone_next = 1'b0;
        end
    end

    // End record and placement of the records in output order.
    // The fixed fields also count as complete when this word is the last of them.
    always_comb begin
        end_rec      = '0;
        end_rec.kind = pmt_pp_pkg::REC_END;
        end_rec.ok   = fdone_reg || (phase_reg == pmt_pp_pkg::PH_LEN_LO);
        rec_a        = '0;
        rec_b        = '0;
        rec_cnt      = 2'd0;
        if (has_main && last_in) begin
            rec_a          = main_rec;
            rec_b          = end_rec;
            rec_b.run_last = 1'b1;
            rec_cnt        = 2'd2;
        end else if (has_main) begin
            rec_a          = main_rec;
            rec_a.run_last = 1'b1;
            rec_cnt        = 2'd1;
        end else if (last_in) begin
            rec_a          = end_rec;
            rec_a.run_last = 1'b1;
            rec_cnt        = 2'd1;
        end
    end

    // Parse state registers, updated only when a word is consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pmt_pp_pkg::PH_PCR_HI;
            hidx_reg  <= pmt_pp_pkg::HDR_TYPE;
            left_reg  <= 12'd0;
            high_reg  <= 8'd0;
            pid_reg   <= 13'd0;
            type_reg  <= 8'd0;
            fdone_reg <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            left_reg  <= left_next;
            high_reg  <= high_next;
            pid_reg   <= pid_next;
            type_reg  <= type_next;
            fdone_reg <= fdone_next;
        end
    end

endmodule

// ===== src/pmt_pp_outq.sv =====
// Small output queue of result records; takes up to two records a cycle
// and presents one. Depends on pmt_pp_pkg for the record and status types.
module pmt_pp_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            push_cnt,
    input  pmt_pp_pkg::rec_t      push_a,
    input  pmt_pp_pkg::rec_t      push_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pmt_pp_pkg::rec_t      m_rec,
    output pmt_pp_pkg::oq_status_t status
);

    localparam int PW = pmt_pp_pkg::OQ_PTR_W;
    localparam int CW = pmt_pp_pkg::OQ_CNT_W;

    pmt_pp_pkg::rec_t mem_reg [pmt_pp_pkg::OQ_DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_rec   = mem_reg[head_reg];

    // Room is judged on the stored count alone, so it waits on no receiver.
    assign status.count = count_reg;
    assign status.room  = (count_reg <= CW'(pmt_pp_pkg::OQ_DEPTH - 2));

    always_comb begin
        head_next  = pop ? head_reg + PW'(1) : head_reg;
        tail_next  = tail_reg + PW'(push_cnt);
        count_next = count_reg + CW'(push_cnt) - CW'(pop);
    end

    // Record storage.
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[tail_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[tail_reg + PW'(1)] <= push_b;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/pmt_pp_top.sv =====
// Top level of the PMT section payload parser: input register, parser and
// output queue. Depends on pmt_pp_pkg, pmt_pp_parser and pmt_pp_outq.
//
// Use: section payload words enter on the s_ channel, one byte per word,
// with s_last_byte high on the final byte of a section. Result records
// leave on the m_ channel; m_run_last marks the last record caused by a
// given input word, and a section-end record follows every final byte.
// A word accepted into the input register is parsed from there once the queue
// has room; its records are registered in the queue and offered on m_valid.
// Throughput: one word per cycle while the receiver keeps up and each word
// yields at most one record; a final byte that also yields a data record puts
// out two records, and the single-record output port presents them in turn.
// The output queue accepts a parsed word only with room for two records.
// Reset (aresetn low, synchronous) empties the input register and the queue
// and returns the parser to the first fixed byte of a section.
// When the receiver stalls, the queue fills, the input register holds its
// word and s_ready falls; nothing is lost or repeated.
module pmt_section_payload_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_rec_kind,
    output logic [12:0] m_pid_value,
    output logic [7:0]  m_stream_kind,
    output logic [7:0]  m_desc_byte,
    output logic        m_section_ok,
    output logic        m_run_last
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   fire;
    logic [1:0]             rec_cnt;
    logic [1:0]             push_cnt;
    pmt_pp_pkg::rec_t       rec_a;
    pmt_pp_pkg::rec_t       rec_b;
    pmt_pp_pkg::rec_t       m_rec;
    pmt_pp_pkg::oq_status_t q_status;

    // A held word is parsed once the queue has room for its records.
    assign fire     = in_valid_reg && q_status.room;
    assign s_ready  = !in_valid_reg || fire;
    assign push_cnt = fire ? rec_cnt : 2'd0;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_payload_byte;
            in_last_reg <= s_last_byte;
        end
    end

    pmt_pp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .rec_a   (rec_a),
        .rec_b   (rec_b),
        .rec_cnt (rec_cnt)
    );

    pmt_pp_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push_a   (rec_a),
        .push_b   (rec_b),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rec    (m_rec),
        .status   (q_status)
    );

    assign m_rec_kind    = m_rec.kind;
    assign m_pid_value   = m_rec.pid;
    assign m_stream_kind = m_rec.stype;
    assign m_desc_byte   = m_rec.dbyte;
    assign m_section_ok  = m_rec.ok;
    assign m_run_last    = m_rec.run_last;

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= pmt_pp_pkg::OQ_CNT_W'(pmt_pp_pkg::OQ_DEPTH))
        else $error("output queue count beyond its depth");

    // The fill count follows pushes and pops exactly.
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> q_status.count == $past(q_status.count)
                 + pmt_pp_pkg::OQ_CNT_W'($past(push_cnt))
                 - pmt_pp_pkg::OQ_CNT_W'($past(m_valid && m_ready)))
        else $error("output queue count out of step");

    // A result word is offered exactly when the queue holds a record.
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid == (q_status.count != '0))
        else $error("m_valid disagrees with the queue count");

    // A section-end record is always the last record of its input word.
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rec_kind == pmt_pp_pkg::REC_END) |-> m_run_last)
        else $error("section end record without run_last");

    // Back-pressure on the input only while a word waits in the register.
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && !q_status.room))
        else $error("input stalled with nothing held");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for pmt_section_payload_parser_top: sends sections of PMT payload
// words and checks every result record against a parser model kept in the bench.
// Depends on pmt_pp_pkg and on the RTL of the block.
module tb;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int WORDS_PER_PASS = 265;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } payload_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_payload_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_rec_kind;
    logic [12:0] m_pid_value;
    logic [7:0]  m_stream_kind;
    logic [7:0]  m_desc_byte;
    logic        m_section_ok;
    logic        m_run_last;

    // Words still to be sent, and records the parser is due to produce.
    payload_word_t    payload_words[$];
    pmt_pp_pkg::rec_t records_due[$];
    payload_word_t    next_word;
    pmt_pp_pkg::rec_t due;

    int src_idle_pct = 18;
    int snk_idle_pct = 86;
    int error_count = 0;
    int cycle_count = 0;
    int words_queued = 0;
    int words_accepted = 0;
    int sections_sent = 0;
    int records_checked = 0;
    int stream_entries = 0;
    int desc_bytes_seen = 0;
    int ok_sections = 0;

    // Parser model state.
    pmt_pp_pkg::phase_t pp_phase = pmt_pp_pkg::PH_PCR_HI;
    logic [2:0]  hdr_pos = pmt_pp_pkg::HDR_TYPE;
    logic [11:0] desc_remaining = '0;
    logic [7:0]  high_byte = '0;
    logic [12:0] pid_reg = '0;
    logic [7:0]  type_reg = '0;
    logic        fixed_seen = 1'b0;

    pmt_section_payload_parser_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rec_kind     (m_rec_kind),
        .m_pid_value    (m_pid_value),
        .m_stream_kind  (m_stream_kind),
        .m_desc_byte    (m_desc_byte),
        .m_section_ok   (m_section_ok),
        .m_run_last     (m_run_last)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d records outstanding",
                     cycle_count, records_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic pmt_pp_pkg::rec_t make_rec(pmt_pp_pkg::rec_kind_t kind,
                                                  logic [12:0] pid, logic [7:0] stype,
                                                  logic [7:0] dbyte, logic ok);
        pmt_pp_pkg::rec_t r;
        r.kind     = kind;
        r.pid      = pid;
        r.stype    = stype;
        r.dbyte    = dbyte;
        r.ok       = ok;
        r.run_last = 1'b0;
        return r;
    endfunction

    task automatic reset_parser();
        pp_phase       = pmt_pp_pkg::PH_PCR_HI;
        hdr_pos        = pmt_pp_pkg::HDR_TYPE;
        desc_remaining = '0;
        high_byte      = '0;
        pid_reg        = '0;
        type_reg       = '0;
        fixed_seen     = 1'b0;
    endtask

    // Advances the parser model by one payload byte and queues the records it yields.
    task automatic parse_section_byte(input logic [7:0] b, input logic is_last);
        pmt_pp_pkg::rec_t recs [2];
        int               n;
        logic [15:0]      pair;
        n = 0;
        pair = {high_byte, b};
        case (pp_phase)
            pmt_pp_pkg::PH_PCR_LO: begin
                pid_reg = pair[12:0];
                recs[n] = make_rec(pmt_pp_pkg::REC_PCR, pid_reg, 8'h00, 8'h00, 1'b0);
                n++;
                pp_phase = pmt_pp_pkg::PH_LEN_HI;
            end
            pmt_pp_pkg::PH_LEN_HI: begin
                high_byte = b;
                pp_phase = pmt_pp_pkg::PH_LEN_LO;
            end
            pmt_pp_pkg::PH_LEN_LO: begin
                desc_remaining = pair[11:0];
                fixed_seen = 1'b1;
                hdr_pos = pmt_pp_pkg::HDR_TYPE;
                pp_phase = (desc_remaining != 0) ? pmt_pp_pkg::PH_PROG_DESC
                                                 : pmt_pp_pkg::PH_HEADER;
            end
            pmt_pp_pkg::PH_PROG_DESC: begin
                recs[n] = make_rec(pmt_pp_pkg::REC_PROG_DESC, 13'h0000, 8'h00, b, 1'b0);
                n++;
                desc_remaining = desc_remaining - 12'd1;
                if (desc_remaining == 0) begin
                    hdr_pos = pmt_pp_pkg::HDR_TYPE;
                    pp_phase = pmt_pp_pkg::PH_HEADER;
                end
            end
            pmt_pp_pkg::PH_HEADER: begin
                case (hdr_pos)
                    pmt_pp_pkg::HDR_TYPE: begin
                        type_reg = b;
                        hdr_pos = pmt_pp_pkg::HDR_PID_HI;
                    end
                    pmt_pp_pkg::HDR_PID_HI, pmt_pp_pkg::HDR_LEN_HI: begin
                        high_byte = b;
                        hdr_pos = hdr_pos + 3'd1;
                    end
                    pmt_pp_pkg::HDR_PID_LO: begin
                        pid_reg = pair[12:0];
                        hdr_pos = pmt_pp_pkg::HDR_LEN_HI;
                    end
                    default: begin
                        desc_remaining = pair[11:0];
                        recs[n] = make_rec(pmt_pp_pkg::REC_STREAM, pid_reg, type_reg,
                                           8'h00, 1'b0);
                        n++;
                        hdr_pos = pmt_pp_pkg::HDR_TYPE;
                        pp_phase = (desc_remaining != 0) ? pmt_pp_pkg::PH_ES_DESC
                                                         : pmt_pp_pkg::PH_HEADER;
                    end
                endcase
            end
            pmt_pp_pkg::PH_ES_DESC: begin
                recs[n] = make_rec(pmt_pp_pkg::REC_ES_DESC, pid_reg, type_reg, b, 1'b0);
                n++;
                desc_remaining = desc_remaining - 12'd1;
                if (desc_remaining == 0) begin
                    hdr_pos = pmt_pp_pkg::HDR_TYPE;
                    pp_phase = pmt_pp_pkg::PH_HEADER;
                end
            end
            default: begin
                // The first fixed byte, and any phase code with no meaning.
                high_byte = b;
                pp_phase = pmt_pp_pkg::PH_PCR_LO;
            end
        endcase
        if (is_last) begin
            recs[n] = make_rec(pmt_pp_pkg::REC_END, 13'h0000, 8'h00, 8'h00, fixed_seen);
            n++;
            reset_parser();
        end
        if (n > 0) begin
            recs[n-1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            records_due.push_back(recs[i]);
        end
    endtask

    task automatic add_word(input logic [7:0] data, input logic is_last);
        payload_word_t w;
        w.data = data;
        w.is_last = is_last;
        payload_words.push_back(w);
        words_queued++;
        if (is_last) begin
            sections_sent++;
        end
    endtask

    // Builds one random section: mostly well formed, some cut short, some pure noise.
    task automatic add_random_section();
        logic [7:0] bytes[$];
        int         pick;
        int         plen;
        int         elen;
        int         cut;
        pick = $urandom_range(99);
        if (pick < 88) begin
            bytes.push_back(8'($urandom));
            bytes.push_back(8'($urandom));
            plen = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(3);
            bytes.push_back({4'($urandom), 4'(plen >> 8)});
            bytes.push_back(8'(plen));
            repeat (plen) bytes.push_back(8'($urandom));
            repeat ($urandom_range(3)) begin
                elen = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(3);
                bytes.push_back(8'($urandom));
                bytes.push_back(8'($urandom));
                bytes.push_back(8'($urandom));
                bytes.push_back({4'($urandom), 4'(elen >> 8)});
                bytes.push_back(8'(elen));
                repeat (elen) bytes.push_back(8'($urandom));
            end
            // A share of the well-formed sections is cut short at a random byte.
            if (pick >= 74) begin
                cut = $urandom_range(1, bytes.size());
                while (bytes.size() > cut) void'(bytes.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 16)) bytes.push_back(8'($urandom));
        end
        foreach (bytes[i]) begin
            add_word(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic wait_words_drained();
        while (payload_words.size() != 0 || s_valid) @(posedge aclk);
    endtask

    // Driver: offers the next pending word, holding it until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_section_byte(s_payload_byte, s_last_byte);
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (payload_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_word = payload_words.pop_front();
                    s_valid <= 1'b1;
                    s_payload_byte <= next_word.data;
                    s_last_byte <= next_word.is_last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted record against the oldest one due.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (records_due.size() == 0) begin
                    $error("Unexpected record: kind %0d pid %0h", m_rec_kind, m_pid_value);
                    error_count++;
                end else begin
                    due = records_due.pop_front();
                    records_checked++;
                    if (due.kind == pmt_pp_pkg::REC_STREAM) stream_entries++;
                    if (due.kind == pmt_pp_pkg::REC_PROG_DESC ||
                        due.kind == pmt_pp_pkg::REC_ES_DESC) desc_bytes_seen++;
                    if (due.kind == pmt_pp_pkg::REC_END && due.ok) ok_sections++;
                    if (m_rec_kind !== due.kind) begin
                        $error("rec_kind: expected %0d, got %0d", due.kind, m_rec_kind);
                        error_count++;
                    end
                    if (m_pid_value !== due.pid) begin
                        $error("pid_value: expected %0h, got %0h", due.pid, m_pid_value);
                        error_count++;
                    end
                    if (m_stream_kind !== due.stype) begin
                        $error("stream_kind: expected %0h, got %0h", due.stype, m_stream_kind);
                        error_count++;
                    end
                    if (m_desc_byte !== due.dbyte) begin
                        $error("desc_byte: expected %0h, got %0h", due.dbyte, m_desc_byte);
                        error_count++;
                    end
                    if (m_section_ok !== due.ok) begin
                        $error("section_ok: expected %0b, got %0b", due.ok, m_section_ok);
                        error_count++;
                    end
                    if (m_run_last !== due.run_last) begin
                        $error("run_last: expected %0b, got %0b", due.run_last, m_run_last);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Stimulus and end of run.
    initial begin
        // A lone first byte: no PCR, section not ok.
        add_word(8'hFF, 1'b1);
        // Two bytes with every reserved bit set: PCR of all ones, still short.
        add_word(8'hFF, 1'b0); add_word(8'hFF, 1'b1);
        // Payload ending exactly on the last fixed byte: section ok.
        add_word(8'h01, 1'b0); add_word(8'h02, 1'b0); add_word(8'hF0, 1'b0);
        add_word(8'h03, 1'b1);
        // Zero program-info length with reserved bits set, then a partial header.
        add_word(8'hE0, 1'b0); add_word(8'h00, 1'b0); add_word(8'hF0, 1'b0);
        add_word(8'h00, 1'b0); add_word(8'h00, 1'b0); add_word(8'hFF, 1'b1);
        // Full section ending on a stream descriptor byte, two records on the last word.
        add_word(8'h00, 1'b0); add_word(8'h00, 1'b0); add_word(8'h00, 1'b0);
        add_word(8'h02, 1'b0); add_word(8'h55, 1'b0); add_word(8'hAA, 1'b0);
        add_word(8'h1B, 1'b0); add_word(8'hE1, 1'b0); add_word(8'h00, 1'b0);
        add_word(8'hF0, 1'b0); add_word(8'h01, 1'b0); add_word(8'h7F, 1'b1);
        // Largest program-info length, clipped by the end of the payload.
        add_word(8'h12, 1'b0); add_word(8'h34, 1'b0); add_word(8'hFF, 1'b0);
        add_word(8'hFF, 1'b0); add_word(8'h00, 1'b1);

        // Sender lightly idle, receiver mostly stalled.
        while (words_queued < WORDS_PER_PASS) add_random_section();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait_words_drained();

        // The other way round.
        src_idle_pct = 86;
        snk_idle_pct = 18;
        while (words_queued < 2 * WORDS_PER_PASS) add_random_section();
        wait_words_drained();

        // Neither side idles.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (words_queued < 3 * WORDS_PER_PASS) add_random_section();
        wait_words_drained();

        while (records_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d payload words in %0d sections; checked %0d records.",
                 words_accepted, sections_sent, records_checked);
        $display("Seen %0d stream entries, %0d descriptor bytes, %0d complete sections.",
                 stream_entries, desc_bytes_seen, ok_sections);
        if (error_count == 0 && records_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pmt_pp_pkg.sv
src/pmt_pp_parser.sv
src/pmt_pp_outq.sv
src/pmt_pp_top.sv
tb/tb.sv
